### hw/rtl/bvz_pkg.sv
// Package for the bounded varint / zigzag reader.
// Holds the item types, limits and register indexes; no dependencies.
`timescale 1ns / 1ps

package bvz_pkg;

  localparam int MAX_VARINT_BYTES = 10;
  localparam int POS_W            = 4;
  localparam int VALUE_W          = 64;
  localparam int SHAMT_W          = 7;

  localparam int LAST_REMAIN = VALUE_W - 7 * (MAX_VARINT_BYTES - 1);
  localparam logic [7:0] LAST_BYTE_MASK =
    (LAST_REMAIN >= 7) ? 8'h7f : 8'((1 << LAST_REMAIN) - 1);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_VARINT_BYTES - 1);

  localparam logic [VALUE_W-1:0] UNSIGNED_LIMIT_RST    = 64'h0000_0000_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] SIGNED_CODE_LIMIT_RST = (64'd1 << 34) - 64'd1;

  typedef enum logic {
    REG_UNSIGNED_LIMIT    = 1'b0,
    REG_SIGNED_CODE_LIMIT = 1'b1
  } reg_index_t;

  typedef enum logic {
    KIND_UNSIGNED = 1'b0,
    KIND_ZIGZAG   = 1'b1
  } kind_t;

  typedef struct packed {
    logic       new_block;
    logic       action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] field_value;
    logic                      is_signed;
    logic                      error;
  } res_item_t;

  typedef struct packed {
    logic       valid;
    in_item_t   item;
  } in_stage_t;

endpackage

### hw/rtl/bvz_in_stage.sv
// Input register stage of the varint reader.
// Depends on bvz_pkg.
`timescale 1ns / 1ps

module bvz_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bvz_pkg::in_item_t  in_item,
  output bvz_pkg::in_stage_t stage,
  input  logic               take
);
  import bvz_pkg::*;

  logic     valid;
  in_item_t item;

  assign in_ready = !valid || take;
  assign stage    = '{valid: valid, item: item};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

### hw/rtl/bvz_decode.sv
// Varint assembly, limit check and zigzag decode; holds the decode state
// and the limit registers. Depends on bvz_pkg.
`timescale 1ns / 1ps

module bvz_decode (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [bvz_pkg::VALUE_W-1:0] cfg_wdata,
  input  bvz_pkg::in_stage_t          stage,
  input  logic                        out_room,
  output logic                        take,
  output logic                        res_valid,
  output bvz_pkg::res_item_t          res
);
  import bvz_pkg::*;

  logic [VALUE_W-1:0] unsigned_limit;
  logic [VALUE_W-1:0] signed_code_limit;
  logic [VALUE_W-1:0] accumulator, accumulator_next;
  logic [POS_W-1:0]   byte_position, byte_position_next;
  logic               error_sticky, error_sticky_next;

  logic [VALUE_W-1:0] acc_base, acc_new, limit, zz;
  logic [POS_W-1:0]   pos_base, idx;
  logic [SHAMT_W-1:0] shamt;
  logic               sticky_base, at_last, bad_last, bad, cont;
  in_item_t           it;

  assign take = stage.valid && out_room;
  assign it   = stage.item;

  always_comb begin
    acc_base    = it.new_block ? '0 : accumulator;
    pos_base    = it.new_block ? '0 : byte_position;
    sticky_base = it.new_block ? 1'b0 : error_sticky;
    at_last     = pos_base >= LAST_POS;
    idx         = at_last ? LAST_POS : pos_base;
    bad_last    = at_last && (it.data_byte > LAST_BYTE_MASK);
    shamt       = SHAMT_W'(idx) * SHAMT_W'(7);
    acc_new     = acc_base | (VALUE_W'(it.data_byte[6:0]) << shamt);
    cont        = it.data_byte[7];
    limit       = (it.action == KIND_ZIGZAG) ? signed_code_limit : unsigned_limit;
    bad         = bad_last || ((idx != '0) && (it.data_byte == 8'd0)) || (acc_new > limit);
    zz          = (acc_new >> 1) ^ {VALUE_W{acc_new[0]}};

    accumulator_next   = acc_base;
    byte_position_next = pos_base;
    error_sticky_next  = sticky_base;
    res_valid          = 1'b0;
    res.is_signed      = it.action;
    res.error          = bad;
    res.field_value    = '0;
    if (!bad) begin
      res.field_value = (it.action == KIND_ZIGZAG) ? zz : acc_new;
    end

    if (!sticky_base) begin
      if (!bad_last && cont) begin
        accumulator_next   = acc_new;
        byte_position_next = idx + POS_W'(1);
      end else begin
        accumulator_next   = '0;
        byte_position_next = '0;
        error_sticky_next  = bad;
        res_valid          = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator   <= '0;
      byte_position <= '0;
      error_sticky  <= 1'b0;
    end else if (take) begin
      accumulator   <= accumulator_next;
      byte_position <= byte_position_next;
      error_sticky  <= error_sticky_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unsigned_limit    <= UNSIGNED_LIMIT_RST;
      signed_code_limit <= SIGNED_CODE_LIMIT_RST;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_UNSIGNED_LIMIT:    unsigned_limit    <= cfg_wdata;
        REG_SIGNED_CODE_LIMIT: signed_code_limit <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/bvz_out_stage.sv
// Result register of the varint reader.
// Depends on bvz_pkg.
`timescale 1ns / 1ps

module bvz_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic               res_valid,
  input  bvz_pkg::res_item_t res,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output bvz_pkg::res_item_t out_item
);
  import bvz_pkg::*;

  logic      valid;
  res_item_t item;

  assign room      = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (room) begin
      valid <= load && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (room && load && res_valid) begin
      item <= res;
    end
  end

endmodule

### hw/rtl/bounded_varint_zigzag_reader_core.sv
// Top level of the bounded varint / zigzag reader.
// Depends on bvz_pkg, bvz_in_stage, bvz_decode, bvz_out_stage.
//
//   channel  dir  payload
//   s_*      in   one varint byte with its kind and new-block mark
//   m_*      out  one decoded field: value, kind, error
//   cfg_*    in   limit register writes, index 0 unsigned, 1 zigzag code
//
// One byte per cycle sustained while m_* does not stall; a result leaves
// through the input register, then the result register, after its final byte.
// Synchronous reset restores the limits and clears decode state.
// A stall on m_* backs up through the result register into s_tready.
`timescale 1ns / 1ps

module bounded_varint_zigzag_reader_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // data_byte
  input  logic [1:0]                  s_tuser,   // action, new_block
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [bvz_pkg::VALUE_W-1:0] m_tdata,   // field_value
  output logic [1:0]                  m_tuser,   // is_signed, error
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [bvz_pkg::VALUE_W-1:0] cfg_wdata
);
  import bvz_pkg::*;

  in_item_t  in_item;
  in_stage_t stage;
  res_item_t res, out_item;
  logic      take, room, res_valid;

  assign in_item.data_byte = s_tdata;
  assign in_item.action    = s_tuser[0];
  assign in_item.new_block = s_tuser[1];

  bvz_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (in_item),
    .stage    (stage),
    .take     (take)
  );

  bvz_decode u_dec (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .stage     (stage),
    .out_room  (room),
    .take      (take),
    .res_valid (res_valid),
    .res       (res)
  );

  bvz_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .res_valid (res_valid),
    .res       (res),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (out_item)
  );

  assign m_tdata = out_item.field_value;
  assign m_tuser = {out_item.error, out_item.is_signed};

endmodule
